[hdl/dvd_pkg.sv]
package dvd_pkg;

    // Fixed field widths
    localparam int POS_W   = 24;
    localparam int TGT_W   = 25;
    localparam int SMO_W   = 40;
    localparam int CNT_W   = 32;
    localparam int ALPHA_W = 25;
    localparam int SPM_W   = 24;
    localparam int CFG_W   = 25;
    localparam int CFG_IDX_W = 1;
    localparam int FRAC_W  = 16;

    // Shared multiplier and accumulator
    localparam int MUL_A_W = 21;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 66;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPM   = 1'b1;

    // Register reset values
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 25'h100_0000;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 25'd13167;
    localparam logic [SPM_W-1:0]   SPM_RST   = 24'd9244246;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SM_LO,
        ST_SM_HI,
        ST_SM_UPD,
        ST_DL_LO,
        ST_DL_HI,
        ST_TGT,
        ST_RD_PRI,
        ST_RD_CUR,
        ST_RD_LAT,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic sm_lo;
        logic sm_hi;
        logic sm_upd;
        logic dl_lo;
        logic dl_hi;
        logic tgt;
        logic rd_pri;
        logic rd_cur;
        logic rd_lat;
        logic mul;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic do_read;
        logic out_free;
    } t_stat;

endpackage

[hdl/dvd_ctrl.sv]
module dvd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dvd_pkg::t_stat i_stat,
    output dvd_pkg::t_cmd  o_cmd
);
    import dvd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SM_LO;
            ST_SM_LO:  n_state = ST_SM_HI;
            ST_SM_HI:  n_state = ST_SM_UPD;
            ST_SM_UPD: n_state = ST_DL_LO;
            ST_DL_LO:  n_state = ST_DL_HI;
            ST_DL_HI:  n_state = ST_TGT;
            ST_TGT:    n_state = ST_RD_PRI;
            ST_RD_PRI: n_state = i_stat.do_read ? ST_RD_CUR : ST_MUL;
            ST_RD_CUR: n_state = ST_RD_LAT;
            ST_RD_LAT: n_state = ST_MUL;
            ST_MUL:    n_state = ST_OUT;
            ST_OUT:    if (i_stat.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SM_LO:  o_cmd.sm_lo  = 1'b1;
            ST_SM_HI:  o_cmd.sm_hi  = 1'b1;
            ST_SM_UPD: o_cmd.sm_upd = 1'b1;
            ST_DL_LO:  o_cmd.dl_lo  = 1'b1;
            ST_DL_HI:  o_cmd.dl_hi  = 1'b1;
            ST_TGT:    o_cmd.tgt    = 1'b1;
            ST_RD_PRI: o_cmd.rd_pri = 1'b1;
            ST_RD_CUR: o_cmd.rd_cur = 1'b1;
            ST_RD_LAT: o_cmd.rd_lat = 1'b1;
            ST_MUL:    o_cmd.mul    = 1'b1;
            ST_OUT:    o_cmd.out_load = i_stat.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[hdl/dvd_datapath.sv]
module dvd_datapath #(
    parameter int RING_DEPTH  = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dvd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dvd_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]     i_audio_in,
    input  logic signed [dvd_pkg::POS_W-1:0]  i_source_pos,
    input  logic signed [dvd_pkg::POS_W-1:0]  i_mic_pos,
    input  dvd_pkg::t_cmd                     i_cmd,
    output dvd_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_audio_out
);
    import dvd_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW:0] DEPTH_V = (AW+1)'(RING_DEPTH);
    localparam longint unsigned WRAP_MOD = 64'h1_0000_0000 % RING_DEPTH;
    localparam logic [AW:0] WRAP_SLOT = (AW+1)'(WRAP_MOD);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
    localparam logic [AW+15:0] DQ_CAP = {AW'(RING_DEPTH - 2), 16'h0000};
    localparam int DQ_W = 41;
    localparam int PROD_W = SAMPLE_BITS + 18;

    // Ring slot of (frame - kk), given frame's own slot
    function automatic logic [AW-1:0] slot_back(
        input logic [CNT_W-1:0] frame,
        input logic [AW-1:0]    fslot,
        input logic [AW:0]      kk
    );
        logic signed [AW+1:0] s;
        if (frame >= CNT_W'(kk)) begin
            s = $signed({2'b00, fslot}) - $signed({1'b0, kk});
        end else begin
            s = $signed({1'b0, WRAP_SLOT}) - $signed({1'b0, kk - frame[AW:0]});
        end
        if (s < 0) begin
            s = s + $signed({1'b0, DEPTH_V});
        end
        return s[AW-1:0];
    endfunction

    // Memories
    logic signed [SAMPLE_BITS-1:0] r_smp_ram [RING_DEPTH];
    logic [POS_W-1:0]              r_pos_ram [RING_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rd_smp;
    logic [POS_W-1:0]              r_rd_pos;
    logic [AW-1:0]                 rd_addr;

    // Configuration
    logic [ALPHA_W-1:0] r_alpha;
    logic [SPM_W-1:0]   r_spm;

    // Counters and filter state
    logic [CNT_W-1:0]          r_wcnt;
    logic [AW-1:0]             r_wslot;
    logic [CNT_W-1:0]          r_rcnt;
    logic [CNT_W-1:0]          r_frame;
    logic [AW-1:0]             r_frame_slot;
    logic signed [SMO_W-1:0]   r_smooth;
    logic signed [TGT_W-1:0]   r_target;
    logic                      r_started;
    logic signed [POS_W-1:0]   r_mic;
    logic [ACC_W-1:0]          r_acc;

    // Read plan
    logic [CNT_W-1:0]          r_tgt;
    logic [AW-1:0]             r_tslot;
    logic [AW-1:0]             r_pslot;
    logic                      r_do_read;
    logic                      r_lag2;
    logic [FRAC_W-1:0]         r_frac;

    // Interpolator
    logic signed [SAMPLE_BITS-1:0] r_prior;
    logic signed [SAMPLE_BITS-1:0] r_cur;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic                          r_out_valid;

    // Combinational
    logic signed [TGT_W-1:0]  start_tgt;
    logic signed [41:0]       d;
    logic [41:0]              d_abs;
    logic                     d_neg;
    logic [40:0]              mag;
    logic [SMO_W-1:0]         smo_abs;
    logic [ALPHA_W-1:0]       alpha_sat;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [MUL_P_W-1:0]       mul_p;
    logic signed [41:0]       smo_ext;
    logic [41:0]              stp;
    logic signed [41:0]       smo_next;
    logic [DQ_W-1:0]          dq;
    logic [AW+15:0]           dq_sat;
    logic [AW-1:0]            di;
    logic [FRAC_W-1:0]        df;
    logic [AW:0]              k;
    logic [CNT_W-1:0]         tgt;
    logic [CNT_W-1:0]         lag;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [SAMPLE_BITS+1:0] interp;

    // Start target, filter error and its magnitude, and the smoothed update
    always_comb begin
        start_tgt = {i_source_pos[POS_W-1], i_source_pos} - {i_mic_pos[POS_W-1], i_mic_pos};
        d = $signed({{2{r_target[TGT_W-1]}}, r_target, 15'b0})
          - $signed({{2{r_smooth[SMO_W-1]}}, r_smooth});
        d_neg = d[41];
        d_abs = d_neg ? (~d + 42'd1) : d;
        mag   = d_abs[40:0];
        smo_abs = r_smooth[SMO_W-1] ? (~r_smooth + SMO_W'(1)) : r_smooth;
        alpha_sat = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
        smo_ext = {{2{r_smooth[SMO_W-1]}}, r_smooth};
        stp = r_acc[ACC_W-1:24];
        smo_next = d_neg ? (smo_ext - $signed(stp)) : (smo_ext + $signed(stp));
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.sm_lo) begin
            mul_a = mag[20:0];
            mul_b = alpha_sat;
        end else if (i_cmd.sm_hi) begin
            mul_a = {1'b0, mag[40:21]};
            mul_b = alpha_sat;
        end else if (i_cmd.dl_lo) begin
            mul_a = {1'b0, smo_abs[19:0]};
            mul_b = {1'b0, r_spm};
        end else if (i_cmd.dl_hi) begin
            mul_a = {1'b0, smo_abs[39:20]};
            mul_b = {1'b0, r_spm};
        end
        mul_p = mul_a * mul_b;
    end

    // Delay, read target and lag
    always_comb begin
        dq     = r_acc[63:23];
        dq_sat = (dq > DQ_W'(DQ_CAP)) ? DQ_CAP : dq[AW+15:0];
        di     = dq_sat[AW+15:16];
        df     = dq_sat[15:0];
        k      = {1'b0, di} + (AW+1)'(df != '0);
        tgt    = r_frame - CNT_W'(k);
        lag    = tgt - r_rcnt + CNT_W'(1);
    end

    // Interpolation
    always_comb begin
        diff   = {r_cur[SAMPLE_BITS-1], r_cur} - {r_prior[SAMPLE_BITS-1], r_prior};
        interp = {{2{r_prior[SAMPLE_BITS-1]}}, r_prior} + r_prod[PROD_W-1:16];
    end

    // Ring write and registered read
    always_comb begin
        rd_addr = i_cmd.rd_pri ? r_pslot : r_tslot;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_smp_ram[r_wslot] <= i_audio_in;
            r_pos_ram[r_wslot] <= i_source_pos;
        end
        r_rd_smp <= r_smp_ram[rd_addr];
        r_rd_pos <= r_pos_ram[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RST;
            r_spm   <= SPM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA: r_alpha <= i_cfg_data;
                CFG_SPM:   r_spm   <= i_cfg_data[SPM_W-1:0];
                default:   r_alpha <= r_alpha;
            endcase
        end
    end

    // Control state: counters, filter, taps, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt      <= '0;
            r_wslot     <= '0;
            r_rcnt      <= '0;
            r_smooth    <= '0;
            r_target    <= '0;
            r_started   <= 1'b0;
            r_prior     <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Take the request and advance the write side
            if (i_cmd.accept) begin
                r_wcnt <= r_wcnt + CNT_W'(1);
                if (r_wslot == LAST_SLOT || r_wcnt == '1) begin
                    r_wslot <= '0;
                end else begin
                    r_wslot <= r_wslot + AW'(1);
                end
                if (!r_started) begin
                    r_target  <= start_tgt;
                    r_smooth  <= {start_tgt, 15'b0};
                    r_started <= 1'b1;
                end
            end
            if (i_cmd.sm_upd) begin
                r_smooth <= smo_next[SMO_W-1:0];
            end
            // Shift the taps; the second read also updates the target and read count
            if (i_cmd.rd_cur) begin
                r_prior <= r_lag2 ? r_rd_smp : r_cur;
            end
            if (i_cmd.rd_lat) begin
                r_cur    <= r_rd_smp;
                r_target <= {r_rd_pos[POS_W-1], r_rd_pos} - {r_mic[POS_W-1], r_mic};
                r_rcnt   <= r_tgt + CNT_W'(1);
            end
            // Hold the result until taken
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mic        <= i_mic_pos;
            r_frame      <= r_wcnt;
            r_frame_slot <= r_wslot;
        end
        if (i_cmd.sm_lo) begin
            r_acc <= ACC_W'(mul_p) + (ACC_W'(1) << 23);
        end
        if (i_cmd.sm_hi) begin
            r_acc <= r_acc + (ACC_W'(mul_p) << 21);
        end
        if (i_cmd.dl_lo) begin
            r_acc <= ACC_W'(mul_p);
        end
        if (i_cmd.dl_hi) begin
            r_acc <= r_acc + (ACC_W'(mul_p) << 20);
        end
        if (i_cmd.tgt) begin
            r_tgt     <= tgt;
            r_tslot   <= slot_back(r_frame, r_frame_slot, k);
            r_pslot   <= slot_back(r_frame, r_frame_slot, k + (AW+1)'(1));
            r_do_read <= (lag != '0) && !lag[CNT_W-1];
            r_lag2    <= (lag != CNT_W'(1));
            r_frac    <= ~df + FRAC_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'($signed({1'b0, r_frac}) * diff);
        end
        // Result lies between the taps, so it fits without clamping
        if (i_cmd.out_load) begin
            r_out <= interp[SAMPLE_BITS-1:0];
        end
    end

    assign o_stat.do_read  = r_do_read;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_audio_out     = r_out;

endmodule

[hdl/doppler_variable_delay.sv]
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_audio_in, i_source_pos, i_mic_pos
// output    o_out_valid / i_out_ready  o_audio_out
// config    i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// After acceptance the sequencer walks two split multiplies (smoothing and delay) on one
// shared 21x25 multiplier, then, when the read pointer advances, two ring reads on a single
// port, and loads the result register; the input stays closed until it returns to idle.
// The result register frees as soon as its request is taken; a stalled output holds
// the sequencer in its last step. Reset is synchronous and needs no clearing pass.
module doppler_variable_delay #(
    parameter int RING_DEPTH  = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dvd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dvd_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_audio_in,
    input  logic signed [dvd_pkg::POS_W-1:0]  i_source_pos,
    input  logic signed [dvd_pkg::POS_W-1:0]  i_mic_pos,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_audio_out
);
    import dvd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dvd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dvd_datapath #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_audio_in   (i_audio_in),
        .i_source_pos (i_source_pos),
        .i_mic_pos    (i_mic_pos),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_audio_out  (o_audio_out)
    );

endmodule

[hdl/dvd_checker.sv]
module dvd_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] o_audio_out
);

    // Reset leaves the block empty and ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_audio_out))
        else $error("stalled result changed");

    // An accepted request keeps the input closed through its first steps
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready)
        else $error("input reopened too early");

    // A new result appears only while the input is closed
    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without a request in work");

endmodule

bind doppler_variable_delay dvd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_audio_out (o_audio_out)
);
